// File: src/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared widths, register indexes, codes and types of the clipped line
// rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 16;
    localparam int DIM_W    = 15;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int ERR_W    = DELTA_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_COLOR    = 2'd2;

    localparam logic [DIM_W-1:0] SPRITE_DIM_RESET = 15'd256;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_BYTE_MASK = 16'h00FF;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COLOR_W-1:0]        t_color;
    typedef logic [DIM_W-1:0]          t_dim;
    typedef logic [DELTA_W-1:0]        t_delta;
    typedef logic signed [ERR_W-1:0]   t_err;

    typedef struct packed {
        t_dim sprite_width;
        t_dim sprite_height;
        logic wide_color;
    } t_cfg;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   write_enable;
        logic   last;
    } t_pixel;

    typedef struct packed {
        logic busy;
        logic emit;
    } t_walk_stat;

endpackage

// File: src/clr_in_if.sv
// ----------------------------------------------------------------------------
// clr_in_if
// Input item channel: start or tick items with endpoints and color.
// ----------------------------------------------------------------------------
interface clr_in_if;
    logic            valid;
    logic            ready;
    logic            kind;
    clr_pkg::t_coord x_a;
    clr_pkg::t_coord y_a;
    clr_pkg::t_coord x_b;
    clr_pkg::t_coord y_b;
    clr_pkg::t_color pen_color;

    modport source (output valid, kind, x_a, y_a, x_b, y_b, pen_color, input ready);
    modport sink   (input valid, kind, x_a, y_a, x_b, y_b, pen_color, output ready);
endinterface

// File: src/clr_out_if.sv
// ----------------------------------------------------------------------------
// clr_out_if
// Pixel result channel: coordinates, color, write enable and last flag.
// ----------------------------------------------------------------------------
interface clr_out_if;
    logic            valid;
    logic            ready;
    clr_pkg::t_coord pixel_x;
    clr_pkg::t_coord pixel_y;
    clr_pkg::t_color pixel_color;
    logic            write_enable;
    logic            last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, last,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, write_enable, last,
                    output ready);
endinterface

// File: src/clr_cfg.sv
// ----------------------------------------------------------------------------
// clr_cfg
// Configuration registers: sprite width, sprite height and color mode.
// ----------------------------------------------------------------------------
module clr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [clr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output clr_pkg::t_cfg                    o_cfg
);
    import clr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= SPRITE_DIM_RESET;
            r_cfg.sprite_height <= SPRITE_DIM_RESET;
            r_cfg.wide_color    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPRITE_WIDTH: begin
                    r_cfg.sprite_width <= i_cfg_data[DIM_W-1:0];
                end
                CFG_SPRITE_HEIGHT: begin
                    r_cfg.sprite_height <= i_cfg_data[DIM_W-1:0];
                end
                CFG_WIDE_COLOR: begin
                    r_cfg.wide_color <= i_cfg_data[0];
                end
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/clr_walker.sv
// ----------------------------------------------------------------------------
// clr_walker
// Line state and one Bresenham step: loads a line on start, forms the
// current pixel and, while busy, steps or ends the line on each accepted tick.
// ----------------------------------------------------------------------------
module clr_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_kind,
    input  clr_pkg::t_coord     i_x_a,
    input  clr_pkg::t_coord     i_y_a,
    input  clr_pkg::t_coord     i_x_b,
    input  clr_pkg::t_coord     i_y_b,
    input  clr_pkg::t_color     i_pen_color,
    input  clr_pkg::t_cfg       i_cfg,
    output clr_pkg::t_pixel     o_pixel,
    output clr_pkg::t_walk_stat o_stat
);
    import clr_pkg::*;

    t_coord r_cur_x, r_cur_y, r_end_x, r_end_y;
    t_delta r_dx, r_dy;
    logic   r_sx_neg, r_sy_neg;
    t_err   r_err;
    t_color r_color;
    logic   r_busy;

    // start decode
    logic   swap;
    t_coord sx_a, sy_a, sx_b, sy_b;
    logic   x_lt, y_lt;
    t_delta start_dx, start_dy;
    t_err   start_err;

    assign swap = (i_x_a == i_x_b && i_y_a > i_y_b) || (i_y_a == i_y_b && i_x_a > i_x_b);
    assign sx_a = swap ? i_x_b : i_x_a;
    assign sy_a = swap ? i_y_b : i_y_a;
    assign sx_b = swap ? i_x_a : i_x_b;
    assign sy_b = swap ? i_y_a : i_y_b;
    assign x_lt = sx_a < sx_b;
    assign y_lt = sy_a < sy_b;

    assign start_dx = x_lt ? ({sx_b[COORD_W-1], sx_b} - {sx_a[COORD_W-1], sx_a})
                           : ({sx_a[COORD_W-1], sx_a} - {sx_b[COORD_W-1], sx_b});
    assign start_dy = y_lt ? ({sy_b[COORD_W-1], sy_b} - {sy_a[COORD_W-1], sy_a})
                           : ({sy_a[COORD_W-1], sy_a} - {sy_b[COORD_W-1], sy_b});
    assign start_err = t_err'({1'b0, start_dx} - {1'b0, start_dy});

    // step
    logic signed [ERR_W:0] e2, neg_dy, pos_dx, sub_dy, add_dx, err_sum;
    logic   step_x, step_y, fin, in_bounds;
    t_coord n_cur_x, n_cur_y;

    assign e2     = {r_err, 1'b0};
    assign pos_dx = $signed({2'b00, r_dx});
    assign neg_dy = -$signed({2'b00, r_dy});
    assign step_x = e2 > neg_dy;
    assign step_y = e2 < pos_dx;
    assign sub_dy = step_x ? $signed({2'b00, r_dy}) : '0;
    assign add_dx = step_y ? pos_dx : '0;
    assign err_sum = {r_err[ERR_W-1], r_err} - sub_dy + add_dx;

    assign n_cur_x = !step_x ? r_cur_x : (r_sx_neg ? r_cur_x - t_coord'(1) : r_cur_x + t_coord'(1));
    assign n_cur_y = !step_y ? r_cur_y : (r_sy_neg ? r_cur_y - t_coord'(1) : r_cur_y + t_coord'(1));

    assign fin = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);

    // nonnegative coordinates fit in the sprite dimension width
    assign in_bounds = !r_cur_x[COORD_W-1] && !r_cur_y[COORD_W-1]
                    && (r_cur_x[DIM_W-1:0] < i_cfg.sprite_width)
                    && (r_cur_y[DIM_W-1:0] < i_cfg.sprite_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_take) begin
            if (i_kind == KIND_START) begin
                r_cur_x  <= sx_a;
                r_cur_y  <= sy_a;
                r_end_x  <= sx_b;
                r_end_y  <= sy_b;
                r_dx     <= start_dx;
                r_dy     <= start_dy;
                r_sx_neg <= !x_lt;
                r_sy_neg <= !y_lt;
                r_err    <= start_err;
                r_color  <= i_pen_color;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (fin) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                    r_err   <= err_sum[ERR_W-1:0];
                end
            end
        end
    end

    assign o_pixel.pixel_x      = r_cur_x;
    assign o_pixel.pixel_y      = r_cur_y;
    assign o_pixel.pixel_color  = i_cfg.wide_color ? r_color : (r_color & COLOR_BYTE_MASK);
    assign o_pixel.write_enable = in_bounds;
    assign o_pixel.last         = fin;

    assign o_stat.busy = r_busy;
    assign o_stat.emit = r_busy && (i_kind == KIND_TICK);

endmodule

// File: src/clipped_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core
// Bresenham line walker with sprite clipping, one pixel per tick item while a line is active.
//
//   channel   dir   handshake       payload
//   i_item    in    valid/ready     kind, x_a, y_a, x_b, y_b, pen_color
//   o_pixel   out   valid/ready     pixel_x, pixel_y, pixel_color, write_enable, last
//   i_cfg_*   in    write enable    register index, data (no read-back)
//
// One item per clock unless a stalled pixel holds the output. A tick while a
// line is active shows its pixel in the cycle after the transfer, from the
// output register; the line state is updated in the same cycle, so the next tick can follow at once.
// Every item, start or tick, waits while the output register is full and
// its pixel is stalled; it is taken in the cycle the pixel drains.
// Reset is synchronous; it leaves the walker idle and the output empty.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clr_in_if.sink                         i_item,
    clr_out_if.source                      o_pixel,
    input  logic                           i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clr_pkg::*;

    t_cfg       cfg;
    t_pixel     pix;
    t_walk_stat stat;
    logic       take;

    t_pixel     r_pix;
    logic       r_out_valid;

    // an output slot is free when empty or being drained this cycle
    assign i_item.ready = !r_out_valid || o_pixel.ready;
    assign take         = i_item.valid && i_item.ready;

    clr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    clr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_kind      (i_item.kind),
        .i_x_a       (i_item.x_a),
        .i_y_a       (i_item.y_a),
        .i_x_b       (i_item.x_b),
        .i_y_b       (i_item.y_b),
        .i_pen_color (i_item.pen_color),
        .i_cfg       (cfg),
        .o_pixel     (pix),
        .o_stat      (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && stat.emit) begin
            r_out_valid <= 1'b1;
            r_pix       <= pix;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pixel.valid        = r_out_valid;
    assign o_pixel.pixel_x      = r_pix.pixel_x;
    assign o_pixel.pixel_y      = r_pix.pixel_y;
    assign o_pixel.pixel_color  = r_pix.pixel_color;
    assign o_pixel.write_enable = r_pix.write_enable;
    assign o_pixel.last         = r_pix.last;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.kind == KIND_START) |=> stat.busy)
        else $error("start transfer did not make the walker busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && stat.emit && pix.last) |=> !stat.busy)
        else $error("walker still busy after the last pixel");

    a_idle_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.kind == KIND_TICK && !stat.busy && !r_out_valid) |=> !r_out_valid)
        else $error("tick while idle produced a pixel");

    a_pixel_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pixel.ready) |=> (r_out_valid && $stable(r_pix)))
        else $error("stalled pixel lost or changed");
`endif

endmodule

// File: dv/clipped_line_rasterizer_core_test.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core_test
// Self-checking bench for the clipped line rasterizer. A queue of start and
// tick items feeds a clocked driver. A line walker in the bench predicts every
// pixel and checks it field by field against the result channel. Both sides
// idle at random, and the sprite size and color mode change between phases.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core_test;

    import clr_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_PHASES  = 7;
    localparam int ITEMS_PER_PHASE = 105;

    typedef struct {
        logic   kind;
        t_coord x_a;
        t_coord y_a;
        t_coord x_b;
        t_coord y_b;
        t_color pen_color;
    } t_raster_req;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    clr_in_if  item_if ();
    clr_out_if pix_if ();

    clipped_line_rasterizer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_pixel    (pix_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_raster_req raster_req_q[$];
    t_pixel      expected_pixels[$];
    int          queued_cnt = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          src_gap_max = 0;
    int          sink_stall_max = 0;

    // configuration as last written
    t_dim cfg_width  = SPRITE_DIM_RESET;
    t_dim cfg_height = SPRITE_DIM_RESET;
    logic cfg_wide   = 1'b1;

    // line walker state
    t_coord walk_x = '0;
    t_coord walk_y = '0;
    t_coord stop_x = '0;
    t_coord stop_y = '0;
    t_delta span_x = '0;
    t_delta span_y = '0;
    logic   neg_x = 1'b0;
    logic   neg_y = 1'b0;
    int     walk_err = 0;
    t_color line_color = '0;
    logic   line_active = 1'b0;

    function automatic void rasterize_item(input t_raster_req req);
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord tmp;
        t_pixel pix;
        int     e2;
        if (req.kind == KIND_START) begin
            ax = req.x_a;
            ay = req.y_a;
            bx = req.x_b;
            by = req.y_b;
            // axis-aligned lines run in increasing coordinate order
            if ((ax == bx && ay > by) || (ay == by && ax > bx)) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            walk_x = ax;
            walk_y = ay;
            stop_x = bx;
            stop_y = by;
            span_x = t_delta'((bx > ax) ? int'(bx) - int'(ax) : int'(ax) - int'(bx));
            span_y = t_delta'((by > ay) ? int'(by) - int'(ay) : int'(ay) - int'(by));
            neg_x = !(ax < bx);
            neg_y = !(ay < by);
            walk_err = int'(span_x) - int'(span_y);
            line_color = req.pen_color;
            line_active = 1'b1;
        end else if (line_active) begin
            pix.pixel_x = walk_x;
            pix.pixel_y = walk_y;
            pix.pixel_color = cfg_wide ? line_color : (line_color & COLOR_BYTE_MASK);
            pix.write_enable = int'(walk_x) >= 0 && int'(walk_y) >= 0 &&
                               int'(walk_x) < int'(cfg_width) &&
                               int'(walk_y) < int'(cfg_height);
            pix.last = (walk_x == stop_x) && (walk_y == stop_y);
            expected_pixels.push_back(pix);
            if (pix.last) begin
                line_active = 1'b0;
            end else begin
                e2 = 2 * walk_err;
                if (e2 > -int'(span_y)) begin
                    walk_err -= int'(span_y);
                    walk_x = walk_x + (neg_x ? -16'sd1 : 16'sd1);
                end
                if (e2 < int'(span_x)) begin
                    walk_err += int'(span_x);
                    walk_y = walk_y + (neg_y ? -16'sd1 : 16'sd1);
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic t_coord clamp_coord(input int v);
        if (v < -32768) return t_coord'(-32768);
        if (v > 32767) return t_coord'(32767);
        return t_coord'(v);
    endfunction

    function automatic int pick_anchor(input int dim);
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, dim);
            2: return 0;
            3: return dim;
            4: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic void push_start(input int xa, input int ya, input int xb,
                                       input int yb, input t_color color);
        t_raster_req req;
        req.kind = KIND_START;
        req.x_a = t_coord'(xa);
        req.y_a = t_coord'(ya);
        req.x_b = t_coord'(xb);
        req.y_b = t_coord'(yb);
        req.pen_color = color;
        raster_req_q.push_back(req);
        queued_cnt++;
    endfunction

    // tick payload is ignored by the block, so it carries noise
    function automatic void push_ticks(input int count);
        t_raster_req req;
        repeat (count) begin
            req.kind = KIND_TICK;
            req.x_a = t_coord'($urandom);
            req.y_a = t_coord'($urandom);
            req.x_b = t_coord'($urandom);
            req.y_b = t_coord'($urandom);
            req.pen_color = t_color'($urandom);
            raster_req_q.push_back(req);
            queued_cnt++;
        end
    endfunction

    function automatic void push_random_line();
        int xa;
        int ya;
        int xb;
        int yb;
        int dx;
        int dy;
        int span;
        int ticks;
        if ($urandom_range(0, 9) == 0) begin
            // long line, cut short by the next start
            xa = int'($signed(16'($urandom)));
            ya = int'($signed(16'($urandom)));
            xb = int'($signed(16'($urandom)));
            yb = int'($signed(16'($urandom)));
            ticks = $urandom_range(1, 6);
        end else begin
            xa = int'(clamp_coord(pick_anchor(int'(cfg_width)) + $urandom_range(0, 12) - 6));
            ya = int'(clamp_coord(pick_anchor(int'(cfg_height)) + $urandom_range(0, 12) - 6));
            xb = int'(clamp_coord(xa + $urandom_range(0, 24) - 12));
            yb = int'(clamp_coord(ya + $urandom_range(0, 24) - 12));
            case ($urandom_range(0, 4))
                0: xb = xa;
                1: yb = ya;
                default: ;
            endcase
            dx = (xb > xa) ? xb - xa : xa - xb;
            dy = (yb > ya) ? yb - ya : ya - yb;
            span = (dx > dy) ? dx : dy;
            ticks = span + 1;
            case ($urandom_range(0, 7))
                0: ticks = $urandom_range(0, span);
                1: ticks += $urandom_range(1, 3);
                default: ;
            endcase
        end
        push_start(xa, ya, xb, yb, t_color'($urandom));
        push_ticks(ticks);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_SPRITE_WIDTH:  cfg_width  = t_dim'(value);
            CFG_SPRITE_HEIGHT: cfg_height = t_dim'(value);
            CFG_WIDE_COLOR:    cfg_wide   = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (raster_req_q.size() != 0 || item_if.valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // item driver
    t_raster_req drv_req;
    int          gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                rasterize_item(drv_req);
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    item_if.valid <= 1'b0;
                    gap_left--;
                end else if (raster_req_q.size() != 0) begin
                    drv_req = raster_req_q.pop_front();
                    item_if.valid     <= 1'b1;
                    item_if.kind      <= drv_req.kind;
                    item_if.x_a       <= drv_req.x_a;
                    item_if.y_a       <= drv_req.y_a;
                    item_if.x_b       <= drv_req.x_b;
                    item_if.y_b       <= drv_req.y_b;
                    item_if.pen_color <= drv_req.pen_color;
                    gap_left = $urandom_range(0, src_gap_max);
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    t_pixel want_pix;
    int     stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel transfer with none expected: x %0d y %0d",
                           pix_if.pixel_x, pix_if.pixel_y);
                    mismatch_cnt++;
                end else begin
                    want_pix = expected_pixels.pop_front();
                    check_field("pixel_x", want_pix.pixel_x, pix_if.pixel_x);
                    check_field("pixel_y", want_pix.pixel_y, pix_if.pixel_y);
                    check_field("pixel_color", want_pix.pixel_color, pix_if.pixel_color);
                    check_field("write_enable", 16'(want_pix.write_enable),
                                16'(pix_if.write_enable));
                    check_field("last", 16'(want_pix.last), 16'(pix_if.last));
                end
                stall_left = $urandom_range(0, sink_stall_max);
            end
            if (stall_left > 0) begin
                pix_if.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** clipped_line_rasterizer_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int phase_no;
        int target;
        int wide_bit;
        item_if.valid     = 1'b0;
        item_if.kind      = KIND_TICK;
        item_if.x_a       = '0;
        item_if.y_a       = '0;
        item_if.x_b       = '0;
        item_if.y_b       = '0;
        item_if.pen_color = '0;
        pix_if.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_SPRITE_WIDTH;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_max    = 8;
        sink_stall_max = 8;
        push_ticks(1);                                  // tick while idle
        push_start(7, 7, 7, 7, 16'hFFFF);               // single point
        push_ticks(1);
        push_start(3, 1, 0, 1, 16'h1234);               // horizontal, right to left
        push_ticks(4);
        push_start(0, 2, 0, 0, 16'h00FF);               // vertical, bottom to top
        push_ticks(3);
        push_start(-1, 257, 1, 255, 16'h8000);          // crosses the sprite corner
        push_ticks(3);
        push_start(-32768, -32768, 32767, 32767, 16'h0000);
        push_ticks(2);
        push_start(32767, -32768, 32765, -32767, 16'h5A5A); // restart while busy
        push_ticks(3);
        push_ticks(1);
        wait_drained();

        for (phase_no = 1; phase_no <= RANDOM_PHASES; phase_no++) begin
            wide_bit = $urandom_range(0, 1);
            case (phase_no)
                1: begin
                    write_reg(CFG_SPRITE_WIDTH, 0);
                    write_reg(CFG_SPRITE_HEIGHT, 0);
                    write_reg(CFG_WIDE_COLOR, 0);
                end
                2: begin
                    write_reg(CFG_SPRITE_WIDTH, 32767);
                    write_reg(CFG_SPRITE_HEIGHT, 32767);
                    write_reg(CFG_WIDE_COLOR, 1);
                end
                3: begin
                    write_reg(CFG_SPRITE_WIDTH, 1);
                    write_reg(CFG_SPRITE_HEIGHT, 1);
                    write_reg(CFG_WIDE_COLOR, ($urandom_range(0, 16383) << 1));
                end
                default: begin
                    write_reg(CFG_SPRITE_WIDTH, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 32767) : $urandom_range(1, 300));
                    write_reg(CFG_SPRITE_HEIGHT, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 32767) : $urandom_range(1, 300));
                    write_reg(CFG_WIDE_COLOR, ($urandom_range(0, 16383) << 1) | wide_bit);
                end
            endcase
            src_gap_max    = (phase_no % 3 == 1) ? 0 : 8;
            sink_stall_max = (phase_no % 3 == 2) ? 0 : 8;

            // carry on with any line left open, now under the new color mode
            push_ticks(2);
            target = queued_cnt + ITEMS_PER_PHASE;
            while (queued_cnt < target) push_random_line();
            // leave a line open across the next register update
            push_start(2, 2, 9, 5, t_color'($urandom));
            push_ticks(2);
            wait_drained();
        end

        push_ticks(10);
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("** clipped_line_rasterizer_core: PASSED **");
        end else begin
            $display("** clipped_line_rasterizer_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
src/clr_pkg.sv
src/clr_in_if.sv
src/clr_out_if.sv
src/clr_cfg.sv
src/clr_walker.sv
src/clipped_line_rasterizer_core.sv
dv/clipped_line_rasterizer_core_test.sv
